// ----- rtl/ffdl_pkg.sv -----
// ffdl_pkg: shared widths, constants, codes and helpers of the fractional delay line
// used by the rtl files of the block other than ffdl_ram; no dependencies

package ffdl_pkg;

    // line store geometry (depth is a power of two, pointers wrap naturally)
    localparam int LINE_DEPTH = 131072;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);

    // sample and delay formats
    localparam int SAMPLE_W = 24;
    localparam int FRAC_W   = 8;
    localparam int POS_W    = LINE_AW + FRAC_W;
    localparam int DLY_W    = 25;
    localparam int OFS_W    = 26;
    localparam int DSUM_W   = OFS_W + 1;
    localparam int GAIN_W   = 15;
    localparam int READ_LAG = 3;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELAY     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOD_ENABLE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_GAIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_GAIN    = 3'd5;

    localparam logic [DLY_W-1:0]  RST_BASE_DELAY = 25'd11289600;
    localparam logic [DLY_W-1:0]  RST_MIN_DELAY  = 25'd11289;
    localparam logic [GAIN_W-1:0] RST_WET_GAIN   = 15'd16384;

    // interpolation and gain arithmetic
    localparam int A_W      = SAMPLE_W + 2;   // n - 2c + p
    localparam int B_W      = SAMPLE_W + 1;   // n - p
    localparam int MA_W     = 36;             // multiplier operand a
    localparam int MB_W     = 16;             // multiplier operand b
    localparam int ACC_W    = 44;             // products and sums
    localparam int GAIN_SH  = 14;
    localparam int INTERP_SH = 2 * FRAC_W + 1;
    localparam int D_W      = ACC_W - INTERP_SH;

    localparam logic signed [ACC_W-1:0] ROUND_GAIN   = ACC_W'(1) <<< (GAIN_SH - 1);
    localparam logic signed [ACC_W-1:0] ROUND_INTERP = ACC_W'(1) <<< (INTERP_SH - 1);

    // sequencer states
    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DLY,
        S_POS,
        S_RDP,
        S_RDC,
        S_RDN,
        S_CAPN,
        S_MAF,
        S_ADD,
        S_MXF,
        S_D,
        S_MFB,
        S_XH,
        S_MBL,
        S_OUT,
        S_DONE
    } t_state;

    // clamp a wide signed value to the sample range
    function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = (ACC_W'(1) <<< (SAMPLE_W - 1)) - ACC_W'(1);
        lo = -(ACC_W'(1) <<< (SAMPLE_W - 1));
        if (v > hi) begin
            sat_sample = hi[SAMPLE_W-1:0];
        end else if (v < lo) begin
            sat_sample = lo[SAMPLE_W-1:0];
        end else begin
            sat_sample = v[SAMPLE_W-1:0];
        end
    endfunction

endpackage

// ----- rtl/ffdl_in_if.sv -----
// ffdl_in_if: input channel of the delay line, one stereo frame plus delay offset
// depends on ffdl_pkg

interface ffdl_in_if;
    import ffdl_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] in_left;
    logic signed [SAMPLE_W-1:0] in_right;
    logic signed [OFS_W-1:0]    delay_offset;

    modport source (output valid, output in_left, output in_right, output delay_offset,
                    input ready);
    modport sink (input valid, input in_left, input in_right, input delay_offset,
                  output ready);
endinterface

// ----- rtl/ffdl_out_if.sv -----
// ffdl_out_if: output channel of the delay line, one processed stereo frame
// depends on ffdl_pkg

interface ffdl_out_if;
    import ffdl_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;

    modport source (output valid, output out_left, output out_right, input ready);
    modport sink (input valid, input out_left, input out_right, output ready);
endinterface

// ----- rtl/ffdl_ram.sv -----
// ffdl_ram: generic simple dual port ram, one write and one registered read port
// no dependencies

module ffdl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/ffdl_mul.sv -----
// ffdl_mul: shared signed multiplier with registered product
// depends on ffdl_pkg for operand and product widths

module ffdl_mul (
    input  logic                              i_clk,
    input  logic signed [ffdl_pkg::MA_W-1:0]  i_a,
    input  logic signed [ffdl_pkg::MB_W-1:0]  i_b,
    output logic signed [ffdl_pkg::ACC_W-1:0] o_p
);
    import ffdl_pkg::*;

    logic signed [MA_W+MB_W-1:0] w_full;
    logic signed [ACC_W-1:0]     r_p;

    // full product, kept to the accumulator width
    assign w_full = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_p <= w_full[ACC_W-1:0];
    end

    assign o_p = r_p;
endmodule

// ----- rtl/fractional_feedback_delay_line.sv -----
// fractional_feedback_delay_line: stereo modulated fractional delay with feedback
// depends on ffdl_pkg, ffdl_in_if, ffdl_out_if, ffdl_ram, ffdl_mul
//
//   port        dir   kind         contents
//   i_in        in    valid/ready  in_left, in_right (Q1.23), delay_offset (Q18.8)
//   o_out       out   valid/ready  out_left, out_right (Q1.23, saturated)
//   i_cfg_*     in    write only   i_cfg_we, i_cfg_idx, i_cfg_data
//
// a frame runs from accept to the next ready through six steps for delay, read position,
// three reads through the single read port of each line ram and capture, then eight
// steps of the shared multiplier for each channel, then one to hand the result over.
// after reset both line rams are zeroed, one entry per cycle over all 131072 entries,
// with ready low; configuration writes are taken during that pass.
// a result waits in the output register while the next frame is accepted; if the
// following result is done before the first is taken, the sequencer holds in its last step.

module fractional_feedback_delay_line (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    ffdl_in_if.sink                              i_in,
    ffdl_out_if.source                           o_out,
    input  logic                                 i_cfg_we,
    input  logic [ffdl_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ffdl_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import ffdl_pkg::*;

    // configuration registers
    logic [DLY_W-1:0]  r_base_delay;
    logic [DLY_W-1:0]  r_min_delay;
    logic              r_mod_enable;
    logic [GAIN_W-1:0] r_wet_gain;
    logic [GAIN_W-1:0] r_feedback_gain;
    logic [GAIN_W-1:0] r_blend_gain;

    // sequencer
    t_state            r_state;
    t_state            n_state;
    logic [LINE_AW-1:0] r_clr_addr;
    logic [LINE_AW-1:0] r_wp;
    logic              r_ch;

    // frame and working registers
    logic signed [SAMPLE_W-1:0] r_in [2];
    logic signed [OFS_W-1:0]    r_ofs;
    logic [DLY_W-1:0]           r_dly;
    logic [POS_W-1:0]           r_pos;
    logic signed [SAMPLE_W-1:0] r_p [2];
    logic signed [SAMPLE_W-1:0] r_c [2];
    logic signed [A_W-1:0]      r_a [2];
    logic signed [B_W-1:0]      r_b [2];
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [D_W-1:0]      r_d;
    logic signed [SAMPLE_W-1:0] r_xh;
    logic signed [SAMPLE_W-1:0] r_y [2];

    // output register
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_l;
    logic signed [SAMPLE_W-1:0] r_out_r;

    // combinational signals
    logic                       w_accept;
    logic                       w_out_free;
    logic signed [DSUM_W-1:0]   w_dsum;
    logic [DLY_W-1:0]           w_dly;
    logic [LINE_AW-1:0]         w_cur;
    logic [FRAC_W-1:0]          w_frac;
    logic [LINE_AW-1:0]         w_raddr;
    logic                       w_re;
    logic [LINE_AW-1:0]         w_waddr;
    logic [SAMPLE_W-1:0]        w_wdata;
    logic                       w_we [2];
    logic [SAMPLE_W-1:0]        w_rdata [2];
    logic signed [SAMPLE_W-1:0] w_xh;
    logic signed [SAMPLE_W-1:0] w_y;
    logic signed [MA_W-1:0]     w_ma;
    logic signed [MB_W-1:0]     w_mb;
    logic signed [ACC_W-1:0]    w_prod;
    logic signed [MB_W-1:0]     w_frac_op;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_delay    <= RST_BASE_DELAY;
            r_min_delay     <= RST_MIN_DELAY;
            r_mod_enable    <= 1'b0;
            r_wet_gain      <= RST_WET_GAIN;
            r_feedback_gain <= '0;
            r_blend_gain    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASE_DELAY:    r_base_delay    <= i_cfg_data[DLY_W-1:0];
                CFG_MIN_DELAY:     r_min_delay     <= i_cfg_data[DLY_W-1:0];
                CFG_MOD_ENABLE:    r_mod_enable    <= i_cfg_data[0];
                CFG_WET_GAIN:      r_wet_gain      <= i_cfg_data[GAIN_W-1:0];
                CFG_FEEDBACK_GAIN: r_feedback_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_BLEND_GAIN:    r_blend_gain    <= i_cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == LINE_AW'(LINE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DLY;
                end
            end
            S_DLY:  n_state = S_POS;
            S_POS:  n_state = S_RDP;
            S_RDP:  n_state = S_RDC;
            S_RDC:  n_state = S_RDN;
            S_RDN:  n_state = S_CAPN;
            S_CAPN: n_state = S_MAF;
            S_MAF:  n_state = S_ADD;
            S_ADD:  n_state = S_MXF;
            S_MXF:  n_state = S_D;
            S_D:    n_state = S_MFB;
            S_MFB:  n_state = S_XH;
            S_XH:   n_state = S_MBL;
            S_MBL:  n_state = S_OUT;
            S_OUT:  n_state = r_ch ? S_DONE : S_MAF;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // clearing address and write pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_wp       <= '0;
        end else begin
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + LINE_AW'(1);
            end
            if (r_state == S_DONE && w_out_free) begin
                r_wp <= r_wp + LINE_AW'(1);
            end
        end
    end

    // delay: base delay, or when modulation is enabled, base plus offset with a lower clamp
    assign w_dsum = $signed({2'b00, r_base_delay}) + DSUM_W'(r_ofs);
    always_comb begin
        if (!r_mod_enable) begin
            w_dly = r_base_delay;
        end else if (w_dsum < $signed({2'b00, r_min_delay})) begin
            w_dly = r_min_delay;
        end else begin
            w_dly = w_dsum[DLY_W-1:0];
        end
    end

    // read position split into sample index and fraction
    assign w_cur  = r_pos[POS_W-1:FRAC_W];
    assign w_frac = r_pos[FRAC_W-1:0];
    assign w_frac_op = $signed({{(MB_W - FRAC_W){1'b0}}, w_frac});

    // line ram addressing
    always_comb begin
        w_re    = 1'b0;
        w_raddr = w_cur;
        case (r_state)
            S_RDP: begin
                w_re    = 1'b1;
                w_raddr = w_cur - LINE_AW'(1);
            end
            S_RDC: begin
                w_re    = 1'b1;
                w_raddr = w_cur;
            end
            S_RDN: begin
                w_re    = 1'b1;
                w_raddr = w_cur + LINE_AW'(1);
            end
            default: begin
            end
        endcase
    end

    // feedback sum to be stored, and output sum
    assign w_xh = sat_sample(((w_prod + ROUND_GAIN) >>> GAIN_SH) + ACC_W'(r_in[r_ch]));
    assign w_y  = sat_sample((r_acc + w_prod + ROUND_GAIN) >>> GAIN_SH);

    assign w_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_wp;
    assign w_wdata = (r_state == S_CLEAR) ? '0 : w_xh;
    assign w_we[0] = (r_state == S_CLEAR) || (r_state == S_XH && !r_ch);
    assign w_we[1] = (r_state == S_CLEAR) || (r_state == S_XH && r_ch);

    // one line ram per channel
    for (genvar g = 0; g < 2; g++) begin : g_line
        ffdl_ram #(
            .WIDTH (SAMPLE_W),
            .DEPTH (LINE_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we[g]),
            .i_waddr (w_waddr),
            .i_wdata (w_wdata),
            .i_re    (w_re),
            .i_raddr (w_raddr),
            .o_rdata (w_rdata[g])
        );
    end

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_MAF: begin
                w_ma = MA_W'(r_a[r_ch]);
                w_mb = w_frac_op;
            end
            S_MXF: begin
                w_ma = $signed(r_acc[MA_W-1:0]);
                w_mb = w_frac_op;
            end
            S_MFB: begin
                w_ma = MA_W'(r_d);
                w_mb = $signed({1'b0, r_feedback_gain});
            end
            S_XH: begin
                w_ma = MA_W'(r_d);
                w_mb = $signed({1'b0, r_wet_gain});
            end
            S_MBL: begin
                w_ma = MA_W'(r_xh);
                w_mb = $signed({1'b0, r_blend_gain});
            end
            default: begin
            end
        endcase
    end

    ffdl_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_prod)
    );

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_in[0] <= i_in.in_left;
                r_in[1] <= i_in.in_right;
                r_ofs   <= i_in.delay_offset;
            end
            S_DLY: r_dly <= w_dly;
            S_POS: begin
                r_pos <= {r_wp, {FRAC_W{1'b0}}} - r_dly
                         - (POS_W'(READ_LAG) << FRAC_W);
            end
            S_RDC: begin
                r_p[0] <= $signed(w_rdata[0]);
                r_p[1] <= $signed(w_rdata[1]);
            end
            S_RDN: begin
                r_c[0] <= $signed(w_rdata[0]);
                r_c[1] <= $signed(w_rdata[1]);
            end
            S_CAPN: begin
                // curvature and slope terms of the quadratic through the three taps
                for (int k = 0; k < 2; k++) begin
                    r_a[k] <= A_W'($signed(w_rdata[k])) - (A_W'(r_c[k]) <<< 1)
                              + A_W'(r_p[k]);
                    r_b[k] <= B_W'($signed(w_rdata[k])) - B_W'(r_p[k]);
                end
                r_ch <= 1'b0;
            end
            S_ADD: r_acc <= w_prod + (ACC_W'(r_b[r_ch]) <<< FRAC_W);
            S_D: begin
                r_d <= D_W'((w_prod + (ACC_W'(r_c[r_ch]) <<< INTERP_SH) + ROUND_INTERP)
                             >>> INTERP_SH);
            end
            S_XH:  r_xh <= w_xh;
            S_MBL: r_acc <= w_prod;
            S_OUT: begin
                r_y[r_ch] <= w_y;
                r_ch      <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_l <= r_y[0];
            r_out_r <= r_y[1];
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.out_left  = r_out_l;
    assign o_out.out_right = r_out_r;
endmodule

// ----- rtl/ffdl_chk.sv -----
// ffdl_chk: port level checks of the delay line, bound to the top level
// depends on ffdl_pkg and fractional_feedback_delay_line

module ffdl_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic signed [ffdl_pkg::SAMPLE_W-1:0] i_out_left,
    input logic signed [ffdl_pkg::SAMPLE_W-1:0] i_out_right
);
    import ffdl_pkg::*;

    logic w_in_acc;
    assign w_in_acc = i_in_valid && i_in_ready;

    // reset leaves no result pending and holds input off during the clearing pass
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_ready)
        else $error("output valid or input ready right after reset");

    // one frame at a time: ready drops after each input transaction
    a_one_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !i_in_ready)
        else $error("input ready still high after an input transaction");

    // no result appears in the cycle after a frame is taken in
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !$rose(i_out_valid))
        else $error("result raised right after an input transaction");

    // a stalled result holds its data
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_left) && $stable(i_out_right))
        else $error("stalled result changed or dropped");
endmodule

bind fractional_feedback_delay_line ffdl_chk u_ffdl_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_left  (o_out.out_left),
    .i_out_right (o_out.out_right)
);
